/* hw/rtl/fcs_pkg.sv */
// Shared types, constants and byte classification for the content type sniffer.
`default_nettype none
package fcs_pkg;

  localparam int MAX_BYTES = 1024;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int HDR_BYTES = 8;
  localparam int FIELD_W   = 11;
  localparam int SIZE_W    = 31;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [31:0] ID_FORM = 32'h464F_524D;
  localparam logic [31:0] ID_CAT  = 32'h4341_5420;
  localparam logic [31:0] ID_LIST = 32'h4C49_5354;
  localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;

  typedef enum logic [1:0] {
    KIND_BINARY = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_IFF    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_TEXT,
    CLS_BIN
  } byte_class_t;

  typedef enum logic [0:0] {
    REG_FILE_SIZE = 1'b0,
    REG_CLIPBOARD = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic        clipboard_iff;
    logic [31:0] win_lo;
    logic [31:0] win_hi;
  } cfg_t;

  typedef struct packed {
    kind_t                file_kind;
    logic [FIELD_W-1:0]   text_count;
    logic [FIELD_W-1:0]   buffer_length;
  } res_t;

  function automatic byte_class_t classify(logic [7:0] b);
    byte_class_t c;
    case (b) inside
      [8'd32:8'd127], [8'd7:8'd13], 8'd17, 8'd19, 8'd27: c = CLS_TEXT;
      8'd155, [8'd160:8'd255]:                           c = CLS_OTHER;
      default:                                           c = CLS_BIN;
    endcase
    return c;
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(logic [CNT_W-1:0] v);
    logic [CNT_W+FIELD_W-1:0] w;
    w = '0;
    w[CNT_W-1:0] = v;
    return w[FIELD_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/fcs_if.sv */
// Valid/ready channel interfaces for input bytes and verdicts.
`default_nettype none
interface fcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface fcs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  file_kind;
  logic [10:0] text_count;
  logic [10:0] buffer_length;

  modport source(output valid, output file_kind, output text_count,
                 output buffer_length, input ready);
  modport sink(input valid, input file_kind, input text_count,
               input buffer_length, output ready);
endinterface
`default_nettype wire

/* hw/rtl/fcs_cfg.sv */
// APB configuration registers and IFF length window bounds.
`default_nettype none
module fcs_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fcs_pkg::CFG_AW-1:0] paddr,
  input  wire logic [fcs_pkg::CFG_DW-1:0] pwdata,
  output logic      [fcs_pkg::CFG_DW-1:0] prdata,
  output fcs_pkg::cfg_t                   cfg
);
  import fcs_pkg::*;

  logic [SIZE_W-1:0] size_r;
  logic              clip_r;
  logic [31:0]       lo_r, hi_r;
  logic [SIZE_W-1:0] wsize;
  logic [63:0]       prod;
  logic [SIZE_W-1:0] q3;
  logic [31:0]       lo_nxt, hi_nxt;
  logic              wr;
  reg_idx_t          idx;

  assign wr    = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[2]);
  assign wsize = pwdata[SIZE_W-1:0];

  // divide by three through the reciprocal, exact for the 31-bit operand
  assign prod   = {33'd0, wsize} * {32'd0, RECIP3};
  assign q3     = prod[63:33];
  assign hi_nxt = {q3[29:0], 2'b00};
  assign lo_nxt = {3'd0, wsize[SIZE_W-1:2]} + {2'd0, wsize[SIZE_W-1:2], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      clip_r <= 1'b0;
      lo_r   <= '0;
      hi_r   <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_FILE_SIZE: begin
          size_r <= wsize;
          lo_r   <= lo_nxt;
          hi_r   <= hi_nxt;
        end
        REG_CLIPBOARD: begin
          clip_r <= pwdata[0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FILE_SIZE: prdata = {1'b0, size_r};
      REG_CLIPBOARD: prdata = {31'd0, clip_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.clipboard_iff = clip_r;
  assign cfg.win_lo        = lo_r;
  assign cfg.win_hi        = hi_r;

endmodule
`default_nettype wire

/* hw/rtl/fcs_scan.sv */
// Per-byte scan state, header capture and verdict logic.
`default_nettype none
module fcs_scan (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  input  wire fcs_pkg::cfg_t cfg,
  output fcs_pkg::res_t      res
);
  import fcs_pkg::*;

  logic [63:0]      hdr_r, hdr_nxt, hdr_upd;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic [CNT_W-1:0] txt_r, txt_nxt, txt_upd;
  logic             bin_r, bin_nxt, bin_upd;
  logic             take;
  byte_class_t      cls;
  logic [31:0]      next_len;
  logic             window, magic;
  logic [CNT_W+1:0] three_cnt;
  logic [CNT_W-1:0] thresh;
  kind_t            kind;

  assign take = cnt_r < CNT_W'(MAX_BYTES);
  assign cls  = classify(data_byte);

  always_comb begin
    hdr_upd = hdr_r;
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (take && cnt_r == CNT_W'(i)) begin
        hdr_upd[63-8*i -: 8] = hdr_r[63-8*i -: 8] | data_byte;
      end
    end
    cnt_upd = take ? cnt_r + CNT_W'(1) : cnt_r;
    txt_upd = txt_r;
    bin_upd = bin_r;
    if (take && !bin_r) begin
      case (cls)
        CLS_TEXT: txt_upd = txt_r + CNT_W'(1);
        CLS_BIN: begin
          txt_upd = '0;
          bin_upd = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign next_len  = hdr_upd[31:0] + 32'd8;
  assign window    = (next_len >= cfg.win_lo) && (next_len <= cfg.win_hi);
  assign magic     = (hdr_upd[63:32] == ID_FORM) || (hdr_upd[63:32] == ID_CAT) ||
                     (hdr_upd[63:32] == ID_LIST);
  assign three_cnt = {2'b00, cnt_upd} + {1'b0, cnt_upd, 1'b0};
  assign thresh    = three_cnt[CNT_W+1:2];

  always_comb begin
    if (cfg.clipboard_iff || (window && magic)) begin
      kind = KIND_IFF;
    end else if (txt_upd > thresh) begin
      kind = KIND_TEXT;
    end else begin
      kind = KIND_BINARY;
    end
  end

  assign res.file_kind     = kind;
  assign res.text_count    = to_field(txt_upd);
  assign res.buffer_length = to_field(cnt_upd);

  always_comb begin
    hdr_nxt = hdr_r;
    cnt_nxt = cnt_r;
    txt_nxt = txt_r;
    bin_nxt = bin_r;
    if (step) begin
      if (last_byte) begin
        hdr_nxt = '0;
        cnt_nxt = '0;
        txt_nxt = '0;
        bin_nxt = 1'b0;
      end else begin
        hdr_nxt = hdr_upd;
        cnt_nxt = cnt_upd;
        txt_nxt = txt_upd;
        bin_nxt = bin_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= '0;
      cnt_r <= '0;
      txt_r <= '0;
      bin_r <= 1'b0;
    end else begin
      hdr_r <= hdr_nxt;
      cnt_r <= cnt_nxt;
      txt_r <= txt_nxt;
      bin_r <= bin_nxt;
    end
  end

  a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> cnt_r == '0 && txt_r == '0 && !bin_r)
    else $error("scan state not cleared after verdict");

  a_text_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    txt_r <= cnt_r)
    else $error("text count exceeds byte count");

  a_binary_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    bin_r |-> txt_r == '0)
    else $error("text count nonzero after binary byte");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BYTES))
    else $error("byte count past bound");

endmodule
`default_nettype wire

/* hw/rtl/file_content_type_sniffer.sv */
// Top level of the content type sniffer: channel registers and submodules.
//
//   port      dir   what one transfer carries
//   in_ch     sink  data_byte, last_byte: one file byte
//   out_ch    src   file_kind, text_count, buffer_length: one verdict
//   cfg_*     APB   file_size at 0x0, clipboard_iff at 0x4
//
// One byte per cycle unless a stalled out_ch holds a last byte; a verdict
// is registered before out_ch. Input register, scan logic, result register.
// A stalled out_ch holds only bytes marked last; other bytes keep flowing.
// Synchronous active-low reset clears the scan state, config and valid flags.
`default_nettype none
module file_content_type_sniffer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  fcs_in_if.sink                          in_ch,
  fcs_out_if.source                       out_ch,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [fcs_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [fcs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [fcs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import fcs_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       a_valid_r, a_valid_nxt;
  logic [7:0] a_byte_r;
  logic       a_last_r;
  logic       a_go;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r;

  assign cfg_pready = 1'b1;

  fcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  fcs_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (a_go),
    .data_byte (a_byte_r),
    .last_byte (a_last_r),
    .cfg       (cfg),
    .res       (res)
  );

  assign a_go        = a_valid_r && (!a_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !a_valid_r || a_go;
  assign a_valid_nxt = in_ch.valid ? 1'b1 : (a_valid_r && !a_go);

  always_comb begin
    if (a_go && a_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= in_ch.ready ? a_valid_nxt : a_valid_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_byte_r <= in_ch.data_byte;
      a_last_r <= in_ch.last_byte;
    end
    if (a_go && a_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.file_kind     = out_res_r.file_kind;
  assign out_ch.text_count    = out_res_r.text_count;
  assign out_ch.buffer_length = out_res_r.buffer_length;

endmodule
`default_nettype wire
